@@ design/scd_pkg.sv @@
// scd_pkg: shared types, opcodes and constants of the SUMP command decoder.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  localparam int NAME_CHARS   = 22;
  localparam int MAX_CAPTURE  = 1048576;
  localparam int NAME_ROM_LEN = 40;
  localparam int NAME_IDX_W   = 6;
  localparam int META_LEN     = NAME_CHARS + 15;
  localparam int CNT_W        = ($clog2(META_LEN) > 6) ? $clog2(META_LEN) : 6;
  localparam int DIV_STEPS    = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CAP_W        = 21;
  localparam int QUEUE_DEPTH  = 2;
  localparam int PTR_W        = 1;
  localparam int ID_LEN       = 4;

  localparam logic [31:0] RESET_CAPTURE    = 32'd4096;
  localparam logic [31:0] RESET_RING       = 32'd4096;
  localparam logic [31:0] RESET_MAX_RATE   = 32'd100000000;
  localparam logic [31:0] RESET_READ_COUNT = RESET_CAPTURE - 32'd1;
  localparam logic [31:0] CAPTURE_FALLBACK = 32'd4096;

  // Short opcodes
  localparam logic [7:0] OP_RESET = 8'h00;
  localparam logic [7:0] OP_ARM   = 8'h01;
  localparam logic [7:0] OP_ID    = 8'h02;
  localparam logic [7:0] OP_META  = 8'h04;
  // Long opcodes
  localparam logic [7:0] OP_SET_DIV     = 8'h80;
  localparam logic [7:0] OP_SET_COUNT   = 8'h81;
  localparam logic [7:0] OP_TRIG_MASK   = 8'hC0;
  localparam logic [7:0] OP_TRIG_VALUE  = 8'hC1;
  localparam logic [7:0] OP_TRIG_MODE   = 8'hC2;

  // Metadata tags
  localparam logic [7:0] TAG_NAME    = 8'h01;
  localparam logic [7:0] TAG_END     = 8'h00;
  localparam logic [7:0] TAG_MEM     = 8'h21;
  localparam logic [7:0] TAG_RATE    = 8'h23;
  localparam logic [7:0] TAG_PROBES  = 8'h40;
  localparam logic [7:0] PROBE_COUNT = 8'h02;

  // Trigger kinds
  localparam logic [2:0] TK_NONE = 3'd0;
  localparam logic [2:0] TK_RISE = 3'd1;
  localparam logic [2:0] TK_FALL = 3'd2;
  localparam logic [2:0] TK_HIGH = 3'd3;
  localparam logic [2:0] TK_LOW  = 3'd4;

  localparam logic [7:0] ID_BYTES [ID_LEN] = '{"1", "A", "L", "S"};

  localparam logic [7:0] DEV_NAME [NAME_ROM_LEN] = '{
    "L", "o", "g", "i", "c", " ", "A", "n", "a", "l", "y", "z", "e", "r", " ",
    "C", "o", "m", "m", "a", "n", "d", " ", "D", "e", "c", "o", "d", "e", "r", " ",
    "R", "e", "f", "e", "r", "e", "n", "c", "e"
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_DEFAULT = 2'd0,
    CFG_RING_CAPACITY   = 2'd1,
    CFG_MAX_RATE        = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CLOSED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_ARM   = 2'd0,
    CMD_ID    = 2'd1,
    CMD_META  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_op_e;

  typedef struct packed {
    logic [31:0] capture_default;
    logic [31:0] ring_capacity;
    logic [31:0] max_rate_hz;
  } cfg_t;

  // One classified command; arm fields are a snapshot taken at the arm byte
  typedef struct packed {
    cmd_op_e          op;
    logic [31:0]      divider;
    logic [2:0]       chan;
    logic [2:0]       tkind;
    logic [CAP_W-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/scd_intf.sv @@
// scd_intf: valid/ready channel interfaces of the SUMP command decoder.
// Depends on scd_pkg for the configuration index width and the count width.
`timescale 1ns / 1ps
`default_nettype none

interface scd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scd_res_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [7:0]               reply_byte;
  logic                     last;
  logic [31:0]              arm_rate;
  logic [2:0]               trig_channel;
  logic [2:0]               trig_kind;
  logic [scd_pkg::CAP_W-1:0] capture_count;

  modport source (output valid, output kind, output reply_byte, output last,
                  output arm_rate, output trig_channel, output trig_kind,
                  output capture_count, input ready);
  modport sink (input valid, input kind, input reply_byte, input last,
                input arm_rate, input trig_channel, input trig_kind,
                input capture_count, output ready);
endinterface

interface scd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scd_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/scd_cfg_regs.sv @@
// scd_cfg_regs: the three configuration registers of the decoder.
// Depends on scd_pkg and the scd_cfg_if interface.
`timescale 1ns / 1ps
`default_nettype none

module scd_cfg_regs (
  input  wire            clk_i,
  input  wire            rst_ni,
  scd_cfg_if.sink        cfg_i,
  output scd_pkg::cfg_t  cfg_o
);

  scd_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_default <= scd_pkg::RESET_CAPTURE;
      cfg_q.ring_capacity   <= scd_pkg::RESET_RING;
      cfg_q.max_rate_hz     <= scd_pkg::RESET_MAX_RATE;
    end else if (cfg_i.valid) begin
      unique case (scd_pkg::cfg_idx_e'(cfg_i.index))
        scd_pkg::CFG_CAPTURE_DEFAULT: cfg_q.capture_default <= cfg_i.data;
        scd_pkg::CFG_RING_CAPACITY:   cfg_q.ring_capacity   <= cfg_i.data;
        scd_pkg::CFG_MAX_RATE:        cfg_q.max_rate_hz     <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/scd_front.sv @@
// scd_front: takes command bytes, collects long-command parameters, holds the
// session registers and queues classified commands. Depends on scd_pkg, scd_intf.
`timescale 1ns / 1ps
`default_nettype none

module scd_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  scd_byte_if.sink       in_i,
  input  scd_pkg::cfg_t  cfg_i,
  input  wire            full_i,
  output logic           push_o,
  output scd_pkg::cmd_t  cmd_o
);

  logic [31:0] divider_q, divider_d;
  logic [31:0] rdcnt_q, rdcnt_d;
  logic [7:0]  trig_mask_q, trig_mask_d;
  logic [7:0]  trig_value_q, trig_value_d;
  logic [7:0]  trig_mode_q, trig_mode_d;
  logic [7:0]  pending_q, pending_d;
  logic [2:0]  param_idx_q, param_idx_d;
  logic [23:0] param_shift_q, param_shift_d;
  logic        closed_q, closed_d;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] param;
  logic [2:0]  chan;
  logic [2:0]  tkind;
  logic [31:0] cnt;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign b          = in_i.rx_byte;
  assign param      = {b, param_shift_q};

  // Arm snapshot: trigger channel, trigger kind and clamped capture count
  always_comb begin
    chan = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (trig_mask_q[i]) chan = 3'(i);
    end
    if (trig_mode_q >= 8'd1 && trig_mode_q <= 8'd4) begin
      tkind = trig_mode_q[2:0];
    end else if (trig_mask_q != 8'd0) begin
      tkind = trig_value_q[chan] ? scd_pkg::TK_HIGH : scd_pkg::TK_LOW;
    end else begin
      tkind = scd_pkg::TK_NONE;
    end
    cnt = (rdcnt_q != 32'd0) ? (rdcnt_q + 32'd1) : cfg_i.capture_default;
    if (cnt == 32'd0) cnt = scd_pkg::CAPTURE_FALLBACK;
    if (cnt > 32'(scd_pkg::MAX_CAPTURE)) cnt = 32'(scd_pkg::MAX_CAPTURE);
  end

  always_comb begin
    divider_d     = divider_q;
    rdcnt_d       = rdcnt_q;
    trig_mask_d   = trig_mask_q;
    trig_value_d  = trig_value_q;
    trig_mode_d   = trig_mode_q;
    pending_d     = pending_q;
    param_idx_d   = param_idx_q;
    param_shift_d = param_shift_q;
    closed_d      = closed_q;
    push_o        = 1'b0;
    cmd_o.op      = scd_pkg::CMD_CLOSE;
    cmd_o.divider = divider_q;
    cmd_o.chan    = chan;
    cmd_o.tkind   = tkind;
    cmd_o.count   = cnt[scd_pkg::CAP_W-1:0];

    if (accept && !closed_q) begin
      if (param_idx_q != 3'd0) begin
        if (param_idx_q < 3'd4) begin
          unique case (param_idx_q)
            3'd1:    param_shift_d[7:0]   = b;
            3'd2:    param_shift_d[15:8]  = b;
            default: param_shift_d[23:16] = b;
          endcase
          param_idx_d = param_idx_q + 3'd1;
        end else begin
          unique case (pending_q)
            scd_pkg::OP_SET_DIV:    divider_d    = param;
            scd_pkg::OP_SET_COUNT:  rdcnt_d      = param;
            scd_pkg::OP_TRIG_MASK:  trig_mask_d  = param[7:0];
            scd_pkg::OP_TRIG_VALUE: trig_value_d = param[7:0];
            scd_pkg::OP_TRIG_MODE:  trig_mode_d  = param[7:0];
            default: ;  // unknown long command: parameters dropped
          endcase
          param_idx_d   = 3'd0;
          param_shift_d = 24'd0;
        end
      end else if (b[7]) begin
        pending_d     = b;
        param_idx_d   = 3'd1;
        param_shift_d = 24'd0;
      end else begin
        unique case (b)
          scd_pkg::OP_RESET: begin
            divider_d    = 32'd0;
            rdcnt_d      = (cfg_i.capture_default != 32'd0) ?
                           (cfg_i.capture_default - 32'd1) : scd_pkg::RESET_READ_COUNT;
            trig_mask_d  = 8'd0;
            trig_value_d = 8'd0;
            trig_mode_d  = 8'd0;
          end
          scd_pkg::OP_ARM: begin
            push_o   = 1'b1;
            cmd_o.op = scd_pkg::CMD_ARM;
          end
          scd_pkg::OP_ID: begin
            push_o   = 1'b1;
            cmd_o.op = scd_pkg::CMD_ID;
          end
          scd_pkg::OP_META: begin
            push_o   = 1'b1;
            cmd_o.op = scd_pkg::CMD_META;
          end
          default: begin
            push_o   = 1'b1;
            cmd_o.op = scd_pkg::CMD_CLOSE;
            closed_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q     <= 32'd0;
      rdcnt_q       <= scd_pkg::RESET_READ_COUNT;
      trig_mask_q   <= 8'd0;
      trig_value_q  <= 8'd0;
      trig_mode_q   <= 8'd0;
      pending_q     <= 8'd0;
      param_idx_q   <= 3'd0;
      param_shift_q <= 24'd0;
      closed_q      <= 1'b0;
    end else begin
      divider_q     <= divider_d;
      rdcnt_q       <= rdcnt_d;
      trig_mask_q   <= trig_mask_d;
      trig_value_q  <= trig_value_d;
      trig_mode_q   <= trig_mode_d;
      pending_q     <= pending_d;
      param_idx_q   <= param_idx_d;
      param_shift_q <= param_shift_d;
      closed_q      <= closed_d;
    end
  end

  // A closed session stays closed until reset
  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("session reopened without reset");

endmodule

`default_nettype wire

@@ design/scd_cmd_fifo.sv @@
// scd_cmd_fifo: short command queue between the decoder front and back.
// Depends on scd_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module scd_cmd_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  scd_pkg::cmd_t  cmd_i,
  input  wire            pop_i,
  output scd_pkg::cmd_t  cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  scd_pkg::cmd_t                mem_q [scd_pkg::QUEUE_DEPTH];
  logic [scd_pkg::PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [scd_pkg::PTR_W:0]      count_q;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == (scd_pkg::PTR_W + 1)'(scd_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + (scd_pkg::PTR_W + 1)'(1);
      else if (do_pop && !do_push) count_q <= count_q - (scd_pkg::PTR_W + 1)'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (scd_pkg::PTR_W + 1)'(scd_pkg::QUEUE_DEPTH))
    else $error("command queue overflow");

endmodule

`default_nettype wire

@@ design/scd_back.sv @@
// scd_back: executes queued commands, sequencing reply bytes and computing the
// arm rate with a bit-serial divider. Depends on scd_pkg and scd_intf.
`timescale 1ns / 1ps
`default_nettype none

module scd_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  scd_pkg::cfg_t  cfg_i,
  input  scd_pkg::cmd_t  cmd_i,
  input  wire            empty_i,
  output logic           pop_o,
  scd_res_if.source      out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ID,
    ST_META,
    ST_DIV,
    ST_ARM,
    ST_CLOSE
  } state_e;

  state_e                     state_q;
  logic [scd_pkg::CNT_W-1:0]  cnt_q;
  logic [31:0]                quot_q;
  logic [31:0]                rem_q;
  logic [31:0]                dvs_q;
  logic [2:0]                 chan_q;
  logic [2:0]                 tkind_q;
  logic [scd_pkg::CAP_W-1:0]  count_q;

  logic                       out_valid_q;
  scd_pkg::kind_e             kind_q;
  logic [7:0]                 byte_q;
  logic                       last_q;
  logic [31:0]                rate_q;
  logic [2:0]                 tch_q;
  logic [2:0]                 tk_q;
  logic [scd_pkg::CAP_W-1:0]  cap_q;

  logic                       slot_free;
  logic                       load;
  logic [32:0]                trial;
  logic [32:0]                diff;
  logic                       fits;

  function automatic logic [7:0] meta_byte(input logic [scd_pkg::CNT_W-1:0] idx,
                                           input logic [31:0] ring,
                                           input logic [31:0] maxr);
    logic [scd_pkg::CNT_W-1:0] nm;
    logic [scd_pkg::CNT_W-1:0] rel_full;
    logic [3:0]                rel;
    logic [7:0]                res;
    nm       = idx - scd_pkg::CNT_W'(1);
    rel_full = idx - scd_pkg::CNT_W'(scd_pkg::NAME_CHARS + 1);
    rel      = rel_full[3:0];
    if (idx == '0) begin
      res = scd_pkg::TAG_NAME;
    end else if (idx <= scd_pkg::CNT_W'(scd_pkg::NAME_CHARS)) begin
      res = scd_pkg::DEV_NAME[nm[scd_pkg::NAME_IDX_W-1:0]];
    end else begin
      unique case (rel)
        4'd1:    res = scd_pkg::TAG_MEM;
        4'd2:    res = ring[7:0];
        4'd3:    res = ring[15:8];
        4'd4:    res = ring[23:16];
        4'd5:    res = ring[31:24];
        4'd6:    res = scd_pkg::TAG_RATE;
        4'd7:    res = maxr[7:0];
        4'd8:    res = maxr[15:8];
        4'd9:    res = maxr[23:16];
        4'd10:   res = maxr[31:24];
        4'd11:   res = scd_pkg::TAG_PROBES;
        4'd12:   res = scd_pkg::PROBE_COUNT;
        default: res = scd_pkg::TAG_END;  // name terminator and end mark
      endcase
    end
    return res;
  endfunction

  assign slot_free = !out_valid_q || out_o.ready;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  // A result register load this cycle
  assign load      = slot_free && (state_q == ST_ID || state_q == ST_META ||
                                   state_q == ST_ARM || state_q == ST_CLOSE);

  // Restoring division step: dividend bits shift out of quot_q, quotient in
  assign trial = {rem_q, quot_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.reply_byte    = byte_q;
  assign out_o.last          = last_q;
  assign out_o.arm_rate      = rate_q;
  assign out_o.trig_channel  = tch_q;
  assign out_o.trig_kind     = tk_q;
  assign out_o.capture_count = cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      quot_q      <= 32'd0;
      rem_q       <= 32'd0;
      dvs_q       <= 32'd0;
      chan_q      <= 3'd0;
      tkind_q     <= 3'd0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= scd_pkg::KIND_REPLY;
      byte_q      <= 8'd0;
      last_q      <= 1'b0;
      rate_q      <= 32'd0;
      tch_q       <= 3'd0;
      tk_q        <= 3'd0;
      cap_q       <= '0;
    end else begin
      if (out_o.ready && !load) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            cnt_q   <= '0;
            chan_q  <= cmd_i.chan;
            tkind_q <= cmd_i.tkind;
            count_q <= cmd_i.count;
            unique case (cmd_i.op)
              scd_pkg::CMD_ARM: begin
                if (cmd_i.divider == 32'd0) begin
                  quot_q  <= cfg_i.max_rate_hz;
                  state_q <= ST_ARM;
                end else if (cmd_i.divider == '1) begin
                  // divisor wraps to zero
                  quot_q  <= 32'd1;
                  state_q <= ST_ARM;
                end else begin
                  quot_q  <= cfg_i.max_rate_hz;
                  rem_q   <= 32'd0;
                  dvs_q   <= cmd_i.divider + 32'd1;
                  state_q <= ST_DIV;
                end
              end
              scd_pkg::CMD_ID:   state_q <= ST_ID;
              scd_pkg::CMD_META: state_q <= ST_META;
              default:           state_q <= ST_CLOSE;
            endcase
          end
        end

        ST_DIV: begin
          rem_q  <= fits ? diff[31:0] : trial[31:0];
          quot_q <= {quot_q[30:0], fits};
          cnt_q  <= cnt_q + scd_pkg::CNT_W'(1);
          if (cnt_q == scd_pkg::CNT_W'(scd_pkg::DIV_STEPS - 1)) state_q <= ST_ARM;
        end

        ST_ARM: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= scd_pkg::KIND_ARM;
            byte_q      <= 8'd0;
            last_q      <= 1'b1;
            rate_q      <= (quot_q == 32'd0) ? 32'd1 : quot_q;
            tch_q       <= chan_q;
            tk_q        <= tkind_q;
            cap_q       <= count_q;
            state_q     <= ST_IDLE;
          end
        end

        ST_ID: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= scd_pkg::KIND_REPLY;
            byte_q      <= scd_pkg::ID_BYTES[cnt_q[1:0]];
            last_q      <= (cnt_q == scd_pkg::CNT_W'(scd_pkg::ID_LEN - 1));
            rate_q      <= 32'd0;
            tch_q       <= 3'd0;
            tk_q        <= 3'd0;
            cap_q       <= '0;
            cnt_q       <= cnt_q + scd_pkg::CNT_W'(1);
            if (cnt_q == scd_pkg::CNT_W'(scd_pkg::ID_LEN - 1)) state_q <= ST_IDLE;
          end
        end

        ST_META: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= scd_pkg::KIND_REPLY;
            byte_q      <= meta_byte(cnt_q, cfg_i.ring_capacity, cfg_i.max_rate_hz);
            last_q      <= (cnt_q == scd_pkg::CNT_W'(scd_pkg::META_LEN - 1));
            rate_q      <= 32'd0;
            tch_q       <= 3'd0;
            tk_q        <= 3'd0;
            cap_q       <= '0;
            cnt_q       <= cnt_q + scd_pkg::CNT_W'(1);
            if (cnt_q == scd_pkg::CNT_W'(scd_pkg::META_LEN - 1)) state_q <= ST_IDLE;
          end
        end

        ST_CLOSE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= scd_pkg::KIND_CLOSED;
            byte_q      <= 8'd0;
            last_q      <= 1'b1;
            rate_q      <= 32'd0;
            tch_q       <= 3'd0;
            tk_q        <= 3'd0;
            cap_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Arm and close requests are always single results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != scd_pkg::KIND_REPLY) |-> last_q)
    else $error("arm or close request without last");

  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == scd_pkg::KIND_ARM) |-> (rate_q != 32'd0))
    else $error("arm request with zero sample rate");

  a_div_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dvs_q > 32'd1))
    else $error("divider running with trivial divisor");

endmodule

`default_nettype wire

@@ design/sump_command_decoder.sv @@
// sump_command_decoder: top level of the SUMP command decoder.
// Depends on scd_pkg, scd_intf, scd_cfg_regs, scd_front, scd_cmd_fifo, scd_back.
//
//   port    dir  handshake     payload
//   cfg_i   in   valid/ready   index (register number), data (32 bit)
//   in_i    in   valid/ready   rx_byte
//   out_o   out  valid/ready   kind, reply_byte, last, arm_rate,
//                              trig_channel, trig_kind, capture_count
//
// The front takes one byte per cycle while the two-entry command queue has room.
// Back: ID gives 4 bytes and META 37 bytes, one byte per cycle while the output
// is free, after a dispatch in the idle state; close and arm give one result, arm
// after the 32-step serial divider when it runs. Output stalls hold the back, then
// fill the queue and drop in_i.ready. Reset is asynchronous, active low, and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module sump_command_decoder (
  input  wire       clk_i,
  input  wire       rst_ni,
  scd_cfg_if.sink   cfg_i,
  scd_byte_if.sink  in_i,
  scd_res_if.source out_o
);

  scd_pkg::cfg_t cfg;
  scd_pkg::cmd_t push_cmd;
  scd_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  scd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  scd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  scd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  scd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
